@@ rtl/aabb_affine_transform_bounds_unit_macros.svh @@
// ----------------------------------------------------------------------------
// aabb affine transform bounds unit assertion macros
// shared concurrent assertion forms for the bounds unit checkers
// ----------------------------------------------------------------------------
`ifndef AABB_AFFINE_TRANSFORM_BOUNDS_UNIT_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_BOUNDS_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define AABB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define AABB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ rtl/aabb_pkg.sv @@
// ----------------------------------------------------------------------------
// aabb_pkg
// types and constants of the transformed bounding box unit
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

	localparam int NUM_AXES   = 3;
	localparam int COORD_W    = 32;
	localparam int COEF_W     = 16;
	localparam int ROW_W      = NUM_AXES * COEF_W;
	localparam int PROD_W     = COORD_W + COEF_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int FRAC_SHIFT = 14;
	localparam int IDX_W      = 3;
	localparam int PIPE_DEPTH = 5;

	// reset values give the identity matrix and no translation
	localparam logic [ROW_W-1:0]   ROW_X_RESET = 48'h0000_0000_4000;
	localparam logic [ROW_W-1:0]   ROW_Y_RESET = 48'h0000_4000_0000;
	localparam logic [ROW_W-1:0]   ROW_Z_RESET = 48'h4000_0000_0000;
	localparam logic [COORD_W-1:0] OFFSET_RESET = '0;

	typedef enum logic [IDX_W-1:0] {
		REG_ROW_X    = 3'd0,
		REG_ROW_Y    = 3'd1,
		REG_ROW_Z    = 3'd2,
		REG_OFFSET_X = 3'd3,
		REG_OFFSET_Y = 3'd4,
		REG_OFFSET_Z = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_min_x;
		logic signed [COORD_W-1:0] in_min_y;
		logic signed [COORD_W-1:0] in_min_z;
		logic signed [COORD_W-1:0] in_max_x;
		logic signed [COORD_W-1:0] in_max_y;
		logic signed [COORD_W-1:0] in_max_z;
	} box_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_min_x;
		logic signed [COORD_W-1:0] out_min_y;
		logic signed [COORD_W-1:0] out_min_z;
		logic signed [COORD_W-1:0] out_max_x;
		logic signed [COORD_W-1:0] out_max_y;
		logic signed [COORD_W-1:0] out_max_z;
	} bounds_t;

endpackage

`default_nettype wire

@@ rtl/aabb_affine_transform_bounds_unit.sv @@
// ----------------------------------------------------------------------------
// aabb_affine_transform_bounds_unit
// axis-aligned bounds of a box after a programmable 3x4 affine transform
// ----------------------------------------------------------------------------
// One request is a box given by its min and max corners in signed Q16.16. The
// unit maps it through the 3x3 Q2.14 matrix plus the Q16.16 translation held
// in the six configuration registers and returns the min and max, per output
// axis, over all eight transformed corners, rounded half up to Q16.16 and
// saturated to 32 bits. Each output axis is done separably: every coefficient
// times coordinate term is split into its smaller and larger choice over the
// two box extremes, which gives the exact corner bounds. The datapath is a
// five-stage pipeline (multiply, min/max select, pair add, final add, round
// and saturate) that takes one box per clock unless a stall backs up to the
// input; the last stage is the output register driving bounds_valid, so a
// stalled result does not block new boxes until all five stages are full. The
// user must write registers through cfg_we/cfg_index/cfg_data only while the
// unit is idle, not enforced here; indexes past the last register are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform_bounds_unit (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration write port
	input  wire                                    cfg_we,
	input  wire  [aabb_pkg::IDX_W-1:0]             cfg_index,
	input  wire  [aabb_pkg::ROW_W-1:0]             cfg_data,
	// box request channel
	input  wire                                    box_valid,
	output logic                                   box_stall,
	input  wire  aabb_pkg::box_t                   box,
	// bounds result channel
	output logic                                   bounds_valid,
	input  wire                                    bounds_stall,
	output aabb_pkg::bounds_t                      bounds
);

	localparam int NA  = aabb_pkg::NUM_AXES;
	localparam int CW  = aabb_pkg::COORD_W;
	localparam int KW  = aabb_pkg::COEF_W;
	localparam int PW  = aabb_pkg::PROD_W;
	localparam int SW  = aabb_pkg::SUM_W;
	localparam int FS  = aabb_pkg::FRAC_SHIFT;
	localparam int QW  = SW - FS;
	localparam logic signed [SW-1:0] ROUND_BIAS = SW'(1) <<< (FS - 1);

	// round half up from Q20.30 to Q16.16, then clamp to 32 bits
	function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] r;
		logic signed [QW-1:0] q;
		logic                 fits;
		r    = s + ROUND_BIAS;
		q    = r[SW-1:FS];
		fits = (q[QW-1:CW-1] == '0) || (q[QW-1:CW-1] == '1);
		if (fits) begin
			round_sat = q[CW-1:0];
		end else if (q[QW-1]) begin
			round_sat = {1'b1, {(CW-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(CW-1){1'b1}}};
		end
	endfunction

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic        [aabb_pkg::ROW_W-1:0] row_q    [NA];
	logic signed [CW-1:0]              offset_q [NA];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]    <= aabb_pkg::ROW_X_RESET;
			row_q[1]    <= aabb_pkg::ROW_Y_RESET;
			row_q[2]    <= aabb_pkg::ROW_Z_RESET;
			offset_q[0] <= aabb_pkg::OFFSET_RESET;
			offset_q[1] <= aabb_pkg::OFFSET_RESET;
			offset_q[2] <= aabb_pkg::OFFSET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				aabb_pkg::REG_ROW_X:    row_q[0]    <= cfg_data;
				aabb_pkg::REG_ROW_Y:    row_q[1]    <= cfg_data;
				aabb_pkg::REG_ROW_Z:    row_q[2]    <= cfg_data;
				aabb_pkg::REG_OFFSET_X: offset_q[0] <= cfg_data[CW-1:0];
				aabb_pkg::REG_OFFSET_Y: offset_q[1] <= cfg_data[CW-1:0];
				aabb_pkg::REG_OFFSET_Z: offset_q[2] <= cfg_data[CW-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// coefficient r,a multiplies input axis a for output axis r
	logic signed [KW-1:0] coef [NA][NA];

	always_comb begin
		for (int r = 0; r < NA; r++) begin
			for (int a = 0; a < NA; a++) begin
				coef[r][a] = row_q[r][a*KW +: KW];
			end
		end
	end

	// ------------------------------------------------------------------
	// pipeline handshake: a stage loads when it is empty or drains
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || !bounds_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign box_stall    = !rdy1;
	assign bounds_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= box_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: the 18 products, one per coefficient and box extreme
	// ------------------------------------------------------------------
	logic signed [CW-1:0] lo_in [NA];
	logic signed [CW-1:0] hi_in [NA];
	logic signed [PW-1:0] prod  [NA][NA][2];
	logic signed [PW-1:0] prod_s1 [NA][NA][2];

	always_comb begin
		lo_in[0] = box.in_min_x;
		lo_in[1] = box.in_min_y;
		lo_in[2] = box.in_min_z;
		hi_in[0] = box.in_max_x;
		hi_in[1] = box.in_max_y;
		hi_in[2] = box.in_max_z;
		for (int r = 0; r < NA; r++) begin
			for (int a = 0; a < NA; a++) begin
				prod[r][a][0] = PW'(coef[r][a]) * PW'(lo_in[a]);
				prod[r][a][1] = PW'(coef[r][a]) * PW'(hi_in[a]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && box_valid) begin
			prod_s1 <= prod;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: split each product pair into smaller and larger term
	// ------------------------------------------------------------------
	// term index: [row][0 = low bound, 1 = high bound][input axis]
	logic signed [PW-1:0] term    [NA][2][NA];
	logic signed [PW-1:0] term_s2 [NA][2][NA];

	always_comb begin
		for (int r = 0; r < NA; r++) begin
			for (int a = 0; a < NA; a++) begin
				if (prod_s1[r][a][0] < prod_s1[r][a][1]) begin
					term[r][0][a] = prod_s1[r][a][0];
					term[r][1][a] = prod_s1[r][a][1];
				end else begin
					term[r][0][a] = prod_s1[r][a][1];
					term[r][1][a] = prod_s1[r][a][0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			term_s2 <= term;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: offset scaled to Q20.30 plus first term, and the other two
	// ------------------------------------------------------------------
	logic signed [SW-1:0] base    [NA];
	logic signed [SW-1:0] part    [NA][2][2];
	logic signed [SW-1:0] part_s3 [NA][2][2];

	always_comb begin
		for (int r = 0; r < NA; r++) begin
			base[r] = SW'(offset_q[r]) <<< FS;
			for (int b = 0; b < 2; b++) begin
				part[r][b][0] = base[r] + SW'(term_s2[r][b][0]);
				part[r][b][1] = SW'(term_s2[r][b][1]) + SW'(term_s2[r][b][2]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			part_s3 <= part;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: full Q20.30 bound per axis
	// ------------------------------------------------------------------
	logic signed [SW-1:0] sum    [NA][2];
	logic signed [SW-1:0] sum_s4 [NA][2];

	always_comb begin
		for (int r = 0; r < NA; r++) begin
			for (int b = 0; b < 2; b++) begin
				sum[r][b] = part_s3[r][b][0] + part_s3[r][b][1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			sum_s4 <= sum;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: round, saturate, output register
	// ------------------------------------------------------------------
	aabb_pkg::bounds_t res;
	aabb_pkg::bounds_t bounds_s5;

	always_comb begin
		res.out_min_x = round_sat(sum_s4[0][0]);
		res.out_min_y = round_sat(sum_s4[1][0]);
		res.out_min_z = round_sat(sum_s4[2][0]);
		res.out_max_x = round_sat(sum_s4[0][1]);
		res.out_max_y = round_sat(sum_s4[1][1]);
		res.out_max_z = round_sat(sum_s4[2][1]);
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			bounds_s5 <= res;
		end
	end

	assign bounds = bounds_s5;

endmodule

`default_nettype wire

@@ rtl/aabb_checker.sv @@
// ----------------------------------------------------------------------------
// aabb_checker
// port-level checks of the bounds unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_affine_transform_bounds_unit_macros.svh"

module aabb_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     box_valid,
	input wire                     box_stall,
	input wire                     bounds_valid,
	input wire                     bounds_stall,
	input wire aabb_pkg::bounds_t  bounds
);

	localparam int CNT_W = $clog2(aabb_pkg::PIPE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(aabb_pkg::PIPE_DEPTH);

	logic             req_acc;
	logic             res_acc;
	logic             res_held;
	logic [CNT_W-1:0] cnt_q;

	assign req_acc  = box_valid && !box_stall;
	assign res_acc  = bounds_valid && !bounds_stall;
	assign res_held = bounds_valid && bounds_stall;

	// requests in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req_acc && !res_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (res_acc && !req_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	`AABB_ASSERT_NEXT(a_result_holds, clk, arst_n, res_held, bounds_valid && $stable(bounds))
	`AABB_ASSERT_IMPL(a_no_orphan_result, clk, arst_n, bounds_valid, cnt_q != '0)
	`AABB_ASSERT_IMPL(a_full_backpressure, clk, arst_n, (cnt_q == DEPTH) && bounds_stall, box_stall)
	`AABB_ASSERT_NEXT(a_latency, clk, arst_n, req_acc ##1 !bounds_stall [*4], bounds_valid)

endmodule

bind aabb_affine_transform_bounds_unit aabb_checker u_aabb_checker (.*);

`default_nettype wire

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// bounds unit check: boxes go through the affine transform, results are
// compared field by field against a fixed point bounds predictor kept here
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import aabb_pkg::*;

	// run shape
	localparam int BOXES_PER_PHASE = 90;
	localparam int NUM_PHASES      = 8;
	localparam int PRESSURE_PHASE  = 3;
	localparam int PRESSURE_BOXES  = 30;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_BURST       = 24;
	localparam int MAX_GAP         = 12;
	localparam int CYCLE_LIMIT     = 100000;

	// handy coefficient and coordinate values
	localparam logic [COEF_W-1:0]  COEF_ONE       = 16'h4000;
	localparam logic [COEF_W-1:0]  COEF_MINUS_ONE = 16'hC000;
	localparam logic [COEF_W-1:0]  COEF_MINUS_TWO = 16'h8000;
	localparam logic [COEF_W-1:0]  COEF_MAX       = 16'h7FFF;
	localparam logic [COEF_W-1:0]  COEF_LSB       = 16'h0001;
	localparam logic [COEF_W-1:0]  COEF_ZERO      = 16'h0000;
	localparam logic [COORD_W-1:0] COORD_MIN      = 32'h8000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX      = 32'h7FFF_FFFF;

	// indexes past the last register, writes there must be dropped
	localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_pattern_t;

	// ------------------------------------------------------------------------
	// bounds predictor and result store
	// ------------------------------------------------------------------------
	class bounds_scoreboard;
		logic [ROW_W-1:0]   rows[NUM_AXES];
		logic [COORD_W-1:0] offsets[NUM_AXES];
		bounds_t            expected_bounds[$];
		int unsigned        boxes_seen;
		int unsigned        bounds_seen;
		int unsigned        mismatches;

		function new();
			rows[0] = ROW_X_RESET;
			rows[1] = ROW_Y_RESET;
			rows[2] = ROW_Z_RESET;
			foreach (offsets[i])
				offsets[i] = OFFSET_RESET;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
			case (idx)
				REG_ROW_X:    rows[0] = data;
				REG_ROW_Y:    rows[1] = data;
				REG_ROW_Z:    rows[2] = data;
				REG_OFFSET_X: offsets[0] = data[COORD_W-1:0];
				REG_OFFSET_Y: offsets[1] = data[COORD_W-1:0];
				REG_OFFSET_Z: offsets[2] = data[COORD_W-1:0];
				default: ;
			endcase
		endfunction

		// q20.30 sum to q16.16, round half up, clamp to 32 bits
		function logic [COORD_W-1:0] round_saturate_q16(longint acc);
			longint q;
			q = (acc + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
			if (q > 64'sd2147483647)
				q = 64'sd2147483647;
			else if (q < -64'sd2147483648)
				q = -64'sd2147483648;
			return q[COORD_W-1:0];
		endfunction

		function bounds_t transform_bounds(box_t b);
			longint             lo_in[NUM_AXES];
			longint             hi_in[NUM_AXES];
			longint             lo, hi, coef, p_lo, p_hi;
			logic [COORD_W-1:0] lo_q[NUM_AXES];
			logic [COORD_W-1:0] hi_q[NUM_AXES];
			bounds_t            res;
			int                 r, a;
			lo_in[0] = b.in_min_x;
			lo_in[1] = b.in_min_y;
			lo_in[2] = b.in_min_z;
			hi_in[0] = b.in_max_x;
			hi_in[1] = b.in_max_y;
			hi_in[2] = b.in_max_z;
			for (r = 0; r < NUM_AXES; r++) begin
				lo = longint'($signed(offsets[r])) <<< FRAC_SHIFT;
				hi = lo;
				for (a = 0; a < NUM_AXES; a++) begin
					coef = longint'($signed(rows[r][a*COEF_W +: COEF_W]));
					p_lo = coef * lo_in[a];
					p_hi = coef * hi_in[a];
					if (p_lo < p_hi) begin
						lo += p_lo;
						hi += p_hi;
					end else begin
						lo += p_hi;
						hi += p_lo;
					end
				end
				lo_q[r] = round_saturate_q16(lo);
				hi_q[r] = round_saturate_q16(hi);
			end
			res.out_min_x = lo_q[0];
			res.out_min_y = lo_q[1];
			res.out_min_z = lo_q[2];
			res.out_max_x = hi_q[0];
			res.out_max_y = hi_q[1];
			res.out_max_z = hi_q[2];
			return res;
		endfunction

		function void note_box(box_t b);
			expected_bounds.push_back(transform_bounds(b));
			boxes_seen++;
		endfunction

		function int pending();
			return expected_bounds.size();
		endfunction

		task report_mismatch(string what);
			$display("[%0t] bounds mismatch, result %0d: %s", $time, bounds_seen, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_bounds(bounds_t got);
			bounds_t want;
			if (expected_bounds.size() == 0) begin
				report_mismatch("result with no box outstanding");
			end else begin
				want = expected_bounds.pop_front();
				compare_field("out_min_x", got.out_min_x, want.out_min_x);
				compare_field("out_min_y", got.out_min_y, want.out_min_y);
				compare_field("out_min_z", got.out_min_z, want.out_min_z);
				compare_field("out_max_x", got.out_max_x, want.out_max_x);
				compare_field("out_max_y", got.out_max_y, want.out_max_y);
				compare_field("out_max_z", got.out_max_z, want.out_max_z);
			end
			bounds_seen++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// signals
	// ------------------------------------------------------------------------
	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [IDX_W-1:0] cfg_index    = '0;
	logic [ROW_W-1:0] cfg_data     = '0;
	logic             box_valid    = 1'b0;
	logic             box_stall;
	box_t             box_payload  = '0;
	logic             bounds_valid;
	logic             bounds_stall = 1'b0;
	bounds_t          bounds_payload;

	bounds_scoreboard sb = new();

	// sender pacing
	int unsigned burst_left    = 0;
	bit          sender_gappy  = 1'b1;
	int unsigned settings_used = 1;

	// receiver pacing, hold-off asked by the stimulus and served by the receiver
	int unsigned hold_off_requests = 0;
	int unsigned hold_off_served   = 0;
	int unsigned hold_left         = 0;
	int unsigned pattern_left      = 0;
	rx_pattern_t rx_pattern        = RX_OPEN;

	int unsigned cycle_count        = 0;
	int unsigned input_stall_cycles = 0;

	aabb_affine_transform_bounds_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.box_valid    (box_valid),
		.box_stall    (box_stall),
		.box          (box_payload),
		.bounds_valid (bounds_valid),
		.bounds_stall (bounds_stall),
		.bounds       (bounds_payload)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// monitor: note accepted requests, check accepted results
	// values read here are the ones present at the edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (box_valid && !box_stall)
				sb.note_box(box_payload);
			if (box_valid && box_stall)
				input_stall_cycles++;
			if (bounds_valid && !bounds_stall)
				sb.check_bounds(bounds_payload);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("aabb_affine_transform_bounds_unit test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// receiver: stall pattern changes every so often, long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_off_served != hold_off_requests) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_off_served++;
		end
		if (pattern_left == 0) begin
			rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
			pattern_left = $urandom_range(20, 200);
		end else begin
			pattern_left--;
		end
		if (hold_left != 0) begin
			// hold the output until the pipe backs up into the request side
			hold_left--;
			bounds_stall <= 1'b1;
		end else begin
			case (rx_pattern)
				RX_OPEN:   bounds_stall <= 1'b0;
				RX_LIGHT:  bounds_stall <= ($urandom_range(0, 7) == 0);
				RX_HEAVY:  bounds_stall <= 1'($urandom_range(0, 1));
				RX_TOGGLE: bounds_stall <= ~bounds_stall;
				default:   bounds_stall <= 1'b0;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic box_t make_box(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
		logic [COORD_W-1:0] z0, logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
		logic [COORD_W-1:0] z1);
		box_t b;
		b.in_min_x = x0;
		b.in_min_y = y0;
		b.in_min_z = z0;
		b.in_max_x = x1;
		b.in_max_y = y1;
		b.in_max_z = z1;
		return b;
	endfunction

	// half of the coordinates modest so results stay in range, the rest extremes or fully random
	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(0, 9))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2, 3, 4: return $urandom;
			default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	function automatic box_t random_box();
		logic signed [COORD_W-1:0] c[6];
		logic signed [COORD_W-1:0] t;
		int                        i;
		for (i = 0; i < 6; i++)
			c[i] = random_coord();
		// most boxes are well formed, the rest keep the random order, which may leave min above max
		if ($urandom_range(0, 4) != 0) begin
			for (i = 0; i < NUM_AXES; i++) begin
				if (c[i] > c[i+3]) begin
					t      = c[i];
					c[i]   = c[i+3];
					c[i+3] = t;
				end
			end
		end
		return make_box(c[0], c[1], c[2], c[3], c[4], c[5]);
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		case ($urandom_range(0, 7))
			0:       return COEF_MINUS_TWO;
			1:       return COEF_MAX;
			2:       return COEF_ZERO;
			3:       return COEF_ONE;
			4:       return COEF_MINUS_ONE;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] random_offset();
		case ($urandom_range(0, 5))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2, 3:    return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
			default: return $urandom;
		endcase
	endfunction

	// one request, held until accepted; bursts with random gaps in between when sender_gappy is set
	task automatic send_box(input box_t b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, MAX_BURST);
			if (sender_gappy) begin
				box_valid <= 1'b0;
				repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
			end
		end
		box_valid   <= 1'b1;
		box_payload <= b;
		@(posedge clk);
		while (box_stall)
			@(posedge clk);
		burst_left--;
	endtask

	// stop offering and let every outstanding result come back
	task automatic wait_for_idle();
		box_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// write enable stays high across a series of writes, end_writes drops it
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic program_random_transform();
		write_reg(REG_ROW_X, {random_coef(), random_coef(), random_coef()});
		write_reg(REG_ROW_Y, {random_coef(), random_coef(), random_coef()});
		write_reg(REG_ROW_Z, {random_coef(), random_coef(), random_coef()});
		// upper data bits are junk for the offset registers
		write_reg(REG_OFFSET_X, {16'($urandom), random_offset()});
		write_reg(REG_OFFSET_Y, {16'($urandom), random_offset()});
		write_reg(REG_OFFSET_Z, {16'($urandom), random_offset()});
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
				{$urandom, 16'($urandom)});
		end_writes();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int phase;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity from reset: zeros, full span, min above max, mixed signs, all at the minimum
		send_box(make_box('0, '0, '0, '0, '0, '0));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(make_box(32'd1, 32'd1, 32'd1, -32'sd1, -32'sd1, -32'sd1));
		send_box(make_box(-32'sd65536, 32'd65536, 32'h7FFF_0000, 32'd65536, -32'sd65536, 32'd1));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));

		// most negative coefficients, top offset with junk above bit 31,
		// then writes to the unused indexes that must change nothing
		wait_for_idle();
		write_reg(REG_ROW_X, {3{COEF_MINUS_TWO}});
		write_reg(REG_ROW_Y, {3{COEF_MINUS_TWO}});
		write_reg(REG_ROW_Z, {3{COEF_MINUS_TWO}});
		write_reg(REG_OFFSET_X, {16'hFFFF, COORD_MAX});
		write_reg(REG_OFFSET_Y, {16'hA5A5, COORD_MAX});
		write_reg(REG_OFFSET_Z, {16'h5A5A, COORD_MAX});
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, '0);
		end_writes();
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box('0, '0, '0, '0, '0, '0));

		// largest positive coefficients, most negative offsets
		wait_for_idle();
		write_reg(REG_ROW_X, {3{COEF_MAX}});
		write_reg(REG_ROW_Y, {3{COEF_MAX}});
		write_reg(REG_ROW_Z, {3{COEF_MAX}});
		write_reg(REG_OFFSET_X, {16'h0000, COORD_MIN});
		write_reg(REG_OFFSET_Y, {16'hFFFF, COORD_MIN});
		write_reg(REG_OFFSET_Z, {16'h0000, COORD_MIN});
		end_writes();
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_box(make_box('0, '0, '0, '0, '0, '0));
		send_box(make_box(32'd5000, COORD_MAX, -32'sd3, -32'sd7000, COORD_MIN, 32'd9));

		// one lsb on the diagonal, zero offsets: half-way rounding goes up
		wait_for_idle();
		write_reg(REG_ROW_X, {COEF_ZERO, COEF_ZERO, COEF_LSB});
		write_reg(REG_ROW_Y, {COEF_ZERO, COEF_LSB, COEF_ZERO});
		write_reg(REG_ROW_Z, {COEF_LSB, COEF_ZERO, COEF_ZERO});
		write_reg(REG_OFFSET_X, '0);
		write_reg(REG_OFFSET_Y, '0);
		write_reg(REG_OFFSET_Z, '0);
		end_writes();
		send_box(make_box(32'd8192, -32'sd8192, 32'd24576, -32'sd24576, 32'd8191, -32'sd8193));
		send_box(make_box(32'd16383, -32'sd16384, 32'd1, 32'd16385, -32'sd1, 32'd40960));
		send_box(make_box(COORD_MIN, COORD_MAX, -32'sd8192, COORD_MAX, COORD_MIN, 32'd8192));

		// random phases, each under its own transform
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			wait_for_idle();
			program_random_transform();
			sender_gappy = ($urandom_range(0, 3) != 0);
			if (phase == PRESSURE_PHASE) begin
				// receiver holds off while boxes keep coming back to back
				hold_off_requests++;
				sender_gappy = 1'b0;
				repeat (PRESSURE_BOXES)
					send_box(random_box());
				sender_gappy = 1'b1;
			end
			repeat (BOXES_PER_PHASE)
				send_box(random_box());
		end

		wait_for_idle();

		$display("run covered %0d boxes and %0d bounds under %0d transform settings",
			sb.boxes_seen, sb.bounds_seen, settings_used);
		$display("request side held off for %0d cycles, %0d mismatches",
			input_stall_cycles, sb.mismatches);
		if (sb.mismatches == 0)
			$display("aabb_affine_transform_bounds_unit test passed");
		else
			$display("aabb_affine_transform_bounds_unit test failed");
		$finish;
	end

endmodule
